// File: sv/agenda_record_stream_parser_core_assert.svh
// Assertion helpers shared by the parser's checking code.
`ifndef AGENDA_RECORD_STREAM_PARSER_CORE_ASSERT_SVH
`define AGENDA_RECORD_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ARSP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("arsp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ARSP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("arsp: next-cycle check failed");

`endif

// File: sv/arsp_pkg.sv
`default_nettype none

package arsp_pkg;

   localparam int MAX_SLOTS = 8;
   localparam int TITLE_CAP = 32;
   localparam int PLACE_CAP = 32;

   // Event counter wide enough to hold MAX_SLOTS itself.
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   localparam logic [7:0] ALL_DAY_MASK = 8'h01;

   // Parser phases.
   localparam logic [3:0] PH_COUNT = 4'd0;
   localparam logic [3:0] PH_START = 4'd1;
   localparam logic [3:0] PH_END   = 4'd2;
   localparam logic [3:0] PH_FLAGS = 4'd3;
   localparam logic [3:0] PH_TLEN  = 4'd4;
   localparam logic [3:0] PH_TITLE = 4'd5;
   localparam logic [3:0] PH_LLEN  = 4'd6;
   localparam logic [3:0] PH_LOC   = 4'd7;
   localparam logic [3:0] PH_DONE  = 4'd8;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_TITLE  = 2'd1;
   localparam logic [1:0] KIND_PLACE  = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   typedef struct packed {
      logic [3:0]       phase;
      logic [CNT_W-1:0] events_wanted;
      logic [CNT_W-1:0] events_done;
      logic [1:0]       byte_in_field;
      logic [31:0]      start_acc;
      logic [31:0]      end_acc;
      logic             flag_bit;
      logic [7:0]       bytes_left;
      logic [7:0]       char_index;
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        slot;
      logic signed [31:0] start_time;
      logic signed [31:0] end_time;
      logic              all_day;
      logic [7:0]        text_char;
      logic [4:0]        text_pos;
      logic              outcome;
      logic [3:0]        event_total;
      logic              run_end;
   } result_type;

   function automatic state_type state_reset();
      state_type s;
      s = '0;
      s.phase = PH_COUNT;
      return s;
   endfunction

endpackage

`default_nettype wire

// File: sv/arsp_channels.sv
`default_nettype none

// Input byte channel.
interface arsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Result channel.
interface arsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [2:0]         slot;
   logic signed [31:0] start_time;
   logic signed [31:0] end_time;
   logic               all_day;
   logic [7:0]         text_char;
   logic [4:0]         text_pos;
   logic               outcome;
   logic [3:0]         event_total;
   logic               run_end;

   modport source (output valid, output kind, output slot, output start_time,
                   output end_time, output all_day, output text_char,
                   output text_pos, output outcome, output event_total,
                   output run_end, input ready);
   modport sink   (input valid, input kind, input slot, input start_time,
                   input end_time, input all_day, input text_char,
                   input text_pos, input outcome, input event_total,
                   input run_end, output ready);
endinterface

`default_nettype wire

// File: sv/agenda_record_stream_parser_core.sv
// Agenda record stream parser. Bytes of a packed agenda buffer enter on the
// req_chan channel, one transaction per byte, with final_byte set on the last
// byte of the buffer. The first byte gives the event count (clamped to the
// slot limit); each event is a little-endian signed start time, an end time,
// a flags byte whose bit 0 marks an all-day event, a title length and the
// title, and a location length and the location. An event header comes out
// on rsp_chan once the fixed part is in, each kept title or location
// character comes out as it arrives, and the final byte adds a status result
// with the outcome and the count of complete events, after which the parser
// is ready for a new buffer. run_end marks the last result of each byte. The
// block takes one byte per clock while rsp_chan is ready: each byte advances
// the phase machine, and a two-entry result buffer feeds the output. A byte
// yields at most two results; only the final byte of a buffer can yield two,
// and while the second of those drains, input is held off. The first result
// of an accepted byte is registered and shown in the cycle after it is taken.

`default_nettype none

`include "agenda_record_stream_parser_core_assert.svh"

module agenda_record_stream_parser_core (
   input wire logic   clock,
   input wire logic   reset,
   arsp_req_if.sink   req_chan,
   arsp_rsp_if.source rsp_chan
);

   // Parser state, updated once per accepted byte.
   arsp_pkg::state_type  state_ff;
   arsp_pkg::state_type  state_in;

   // Two-entry result buffer: head is shown on the output, tail waits.
   arsp_pkg::result_type head_ff;
   arsp_pkg::result_type head_in;
   logic                 head_valid_ff;
   logic                 head_valid_in;
   arsp_pkg::result_type tail_ff;
   arsp_pkg::result_type tail_in;
   logic                 tail_valid_ff;
   logic                 tail_valid_in;

   arsp_pkg::result_type first_res;
   arsp_pkg::result_type second_res;
   logic                 first_valid;
   logic                 second_valid;
   arsp_pkg::state_type  next_state;

   logic take;
   logic pop;

   arsp_decoder u_decoder (
      .cur_state    (state_ff),
      .data_byte    (req_chan.data_byte),
      .final_byte   (req_chan.final_byte),
      .next_state   (next_state),
      .first_res    (first_res),
      .first_valid  (first_valid),
      .second_res   (second_res),
      .second_valid (second_valid)
   );

   // A new byte is taken whenever the buffer will be empty after this cycle.
   assign req_chan.ready = !head_valid_ff || (rsp_chan.ready && !tail_valid_ff);
   assign take = req_chan.valid && req_chan.ready;
   assign pop  = head_valid_ff && rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      tail_in       = tail_ff;
      tail_valid_in = tail_valid_ff;
      if (take) begin
         state_in      = next_state;
         head_in       = first_res;
         head_valid_in = first_valid;
         tail_in       = second_res;
         tail_valid_in = second_valid;
      end else if (pop) begin
         head_in       = tail_ff;
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arsp_pkg::state_reset();
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by the valid flags.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_chan.valid       = head_valid_ff;
   assign rsp_chan.kind        = head_ff.kind;
   assign rsp_chan.slot        = head_ff.slot;
   assign rsp_chan.start_time  = head_ff.start_time;
   assign rsp_chan.end_time    = head_ff.end_time;
   assign rsp_chan.all_day     = head_ff.all_day;
   assign rsp_chan.text_char   = head_ff.text_char;
   assign rsp_chan.text_pos    = head_ff.text_pos;
   assign rsp_chan.outcome     = head_ff.outcome;
   assign rsp_chan.event_total = head_ff.event_total;
   assign rsp_chan.run_end     = head_ff.run_end;

   // The tail entry is only ever the status result behind a primary result.
   `ARSP_ASSERT_IMPLY(a_tail_needs_head, clock, reset, tail_valid_ff, head_valid_ff)
   `ARSP_ASSERT_IMPLY(a_tail_is_status, clock, reset, tail_valid_ff, (tail_ff.kind == arsp_pkg::KIND_STATUS) && !head_ff.run_end && (head_ff.kind != arsp_pkg::KIND_STATUS))
   // Completed events never exceed the wanted count.
   `ARSP_ASSERT_IMPLY(a_done_bounded, clock, reset, 1'b1, state_ff.events_done <= state_ff.events_wanted)
   // A final byte always yields a result and returns the parser to its start.
   `ARSP_ASSERT_NEXT(a_final_restarts, clock, reset, take && req_chan.final_byte, head_valid_ff && (state_ff.phase == arsp_pkg::PH_COUNT))

endmodule

`default_nettype wire

// File: sv/arsp_decoder.sv
`default_nettype none

// Next-state and result logic for one byte of the agenda buffer.
module arsp_decoder (
   input  wire arsp_pkg::state_type  cur_state,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 final_byte,
   output arsp_pkg::state_type       next_state,
   output arsp_pkg::result_type      first_res,
   output logic                      first_valid,
   output arsp_pkg::result_type      second_res,
   output logic                      second_valid
);

   localparam int CNT_W_L = arsp_pkg::CNT_W;

   arsp_pkg::state_type  st;
   arsp_pkg::result_type prim;
   arsp_pkg::result_type stat;
   logic                 prim_valid;
   logic                 evt_finish;
   logic [7:0]           left_dec;
   logic [7:0]           clamped;
   logic [7:0]           char_next;
   logic [31:0]          lane;
   logic                 title_keep;
   logic                 place_keep;
   logic [CNT_W_L-1:0]   done_inc;

   assign left_dec   = (cur_state.bytes_left != 8'd0) ? cur_state.bytes_left - 8'd1 : 8'd0;
   assign clamped    = (data_byte > 8'(arsp_pkg::MAX_SLOTS)) ?
                       8'(arsp_pkg::MAX_SLOTS) : data_byte;
   assign char_next  = (cur_state.char_index != 8'hFF) ? cur_state.char_index + 8'd1 :
                       cur_state.char_index;
   assign lane       = {24'd0, data_byte} << {cur_state.byte_in_field, 3'b000};
   assign title_keep = {1'b0, cur_state.char_index} < 9'(arsp_pkg::TITLE_CAP - 1);
   assign place_keep = {1'b0, cur_state.char_index} < 9'(arsp_pkg::PLACE_CAP - 1);
   assign done_inc   = cur_state.events_done + CNT_W_L'(1);

   always_comb begin
      st         = cur_state;
      prim       = '0;
      prim_valid = 1'b0;
      evt_finish = 1'b0;
      stat       = '0;

      case (cur_state.phase)
         arsp_pkg::PH_COUNT: begin
            st.events_wanted = CNT_W_L'(clamped);
            st.events_done   = '0;
            st.byte_in_field = 2'd0;
            st.phase = (clamped == 8'd0) ? arsp_pkg::PH_DONE : arsp_pkg::PH_START;
         end
         arsp_pkg::PH_START: begin
            st.start_acc     = cur_state.start_acc | lane;
            st.byte_in_field = cur_state.byte_in_field + 2'd1;
            if (cur_state.byte_in_field == 2'd3) begin
               st.phase = arsp_pkg::PH_END;
            end
         end
         arsp_pkg::PH_END: begin
            st.end_acc       = cur_state.end_acc | lane;
            st.byte_in_field = cur_state.byte_in_field + 2'd1;
            if (cur_state.byte_in_field == 2'd3) begin
               st.phase = arsp_pkg::PH_FLAGS;
            end
         end
         arsp_pkg::PH_FLAGS: begin
            st.flag_bit = |(data_byte & arsp_pkg::ALL_DAY_MASK);
            st.phase    = arsp_pkg::PH_TLEN;
         end
         arsp_pkg::PH_TLEN: begin
            prim_valid      = 1'b1;
            prim.kind       = arsp_pkg::KIND_HEADER;
            prim.slot       = 3'(cur_state.events_done);
            prim.start_time = cur_state.start_acc;
            prim.end_time   = cur_state.end_acc;
            prim.all_day    = cur_state.flag_bit;
            st.start_acc    = '0;
            st.end_acc      = '0;
            st.flag_bit     = 1'b0;
            st.bytes_left   = data_byte;
            st.char_index   = 8'd0;
            st.phase = (data_byte == 8'd0) ? arsp_pkg::PH_LLEN : arsp_pkg::PH_TITLE;
         end
         arsp_pkg::PH_TITLE: begin
            prim_valid     = title_keep;
            prim.kind      = arsp_pkg::KIND_TITLE;
            prim.slot      = 3'(cur_state.events_done);
            prim.text_char = data_byte;
            prim.text_pos  = cur_state.char_index[4:0];
            st.char_index  = char_next;
            st.bytes_left  = left_dec;
            if (left_dec == 8'd0) begin
               st.phase = arsp_pkg::PH_LLEN;
            end
         end
         arsp_pkg::PH_LLEN: begin
            st.bytes_left = data_byte;
            st.char_index = 8'd0;
            if (data_byte == 8'd0) begin
               evt_finish = 1'b1;
            end else begin
               st.phase = arsp_pkg::PH_LOC;
            end
         end
         arsp_pkg::PH_LOC: begin
            prim_valid     = place_keep;
            prim.kind      = arsp_pkg::KIND_PLACE;
            prim.slot      = 3'(cur_state.events_done);
            prim.text_char = data_byte;
            prim.text_pos  = cur_state.char_index[4:0];
            st.char_index  = char_next;
            st.bytes_left  = left_dec;
            if (left_dec == 8'd0) begin
               evt_finish = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (evt_finish) begin
         st.events_done   = done_inc;
         st.byte_in_field = 2'd0;
         st.phase = (done_inc >= cur_state.events_wanted) ? arsp_pkg::PH_DONE :
                    arsp_pkg::PH_START;
      end

      if (final_byte) begin
         stat.kind        = arsp_pkg::KIND_STATUS;
         stat.outcome     = (st.phase != arsp_pkg::PH_DONE);
         stat.event_total = 4'(st.events_done);
         stat.run_end     = 1'b1;
         st = arsp_pkg::state_reset();
      end

      next_state = st;

      // The status result follows a primary result of the same byte.
      if (prim_valid) begin
         first_res         = prim;
         first_res.run_end = !final_byte;
         first_valid       = 1'b1;
         second_res        = stat;
         second_valid      = final_byte;
      end else begin
         first_res    = stat;
         first_valid  = final_byte;
         second_res   = stat;
         second_valid = 1'b0;
      end
   end

endmodule

`default_nettype wire
